// File: design/ssm_pkg.sv
// shared types and constants for the sparse set membership core
// no dependencies

package ssm_pkg;

   localparam int OPCODE_W  = 2;
   localparam int ELEMENT_W = 10;
   localparam int COUNT_W   = 11;
   localparam int UNIV_W    = 11;

   typedef logic [OPCODE_W-1:0]  opcode_type;
   typedef logic [ELEMENT_W-1:0] element_type;
   typedef logic [COUNT_W-1:0]   count_type;
   typedef logic [UNIV_W-1:0]    univ_type;

   localparam opcode_type OP_ADD    = 2'd0;
   localparam opcode_type OP_DELETE = 2'd1;
   localparam opcode_type OP_QUERY  = 2'd2;

   localparam univ_type UNIVERSE_RESET = 11'd1024;

endpackage

// File: design/sparse_set_membership_core.sv
// sparse set kept as a permutation and its inverse in two synchronous memories
// depends on ssm_pkg
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   req_opcode, req_element
//   rsp       out        rsp_valid/rsp_stall   rsp_was_member, rsp_member_count,
//                                              rsp_range_error
//   csr       in         csr_wr_en             csr_wr_data (universe size)
//
// a transaction is a memory read, then compare, write and result
// a swap's second write pair lands while the next transaction reads; forwarded
// after reset a clearing pass writes the identity into every slot, req stalled
// result register parts the sides; rsp_stall holds the execute stage

module sparse_set_membership_core
   import ssm_pkg::*;
#(
   parameter int UNIVERSE_MAX = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  opcode_type  req_opcode,
   input  element_type req_element,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_was_member,
   output count_type   rsp_member_count,
   output logic        rsp_range_error,
   input  logic        csr_wr_en,
   input  univ_type    csr_wr_data
);

   localparam int SLOT_W = $clog2(UNIVERSE_MAX);
   localparam int CNT_W  = $clog2(UNIVERSE_MAX + 1);

   logic [SLOT_W-1:0] elem_at_slot_mem [UNIVERSE_MAX];
   logic [SLOT_W-1:0] slot_of_elem_mem [UNIVERSE_MAX];

   univ_type          universe_ff;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic              clr_busy_ff, clr_busy_in;
   logic [SLOT_W-1:0] clr_idx_ff, clr_idx_in;

   logic              ex_valid_ff, ex_valid_in;
   opcode_type        ex_op_ff;
   logic [SLOT_W-1:0] ex_elem_ff;
   logic [SLOT_W-1:0] ex_pos_ff;
   logic              ex_err_ff;
   logic              ex_overlap_ff;

   logic              wb2_ff, wb2_in;
   logic [SLOT_W-1:0] wb2_from_ff, wb2_from_in;
   logic [SLOT_W-1:0] wb2_other_ff, wb2_other_in;

   logic [SLOT_W-1:0] rd_slot_ff;
   logic [SLOT_W-1:0] rd_elem_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_member_ff;
   count_type         rsp_count_ff;
   logic              rsp_err_ff;

   logic              accept;
   logic              advance;
   logic [SLOT_W-1:0] acc_elem;
   logic [SLOT_W-1:0] acc_pos;
   logic              acc_err;
   logic [31:0]       limit;

   logic [SLOT_W-1:0] from_slot;
   logic [SLOT_W-1:0] other_elem;
   logic              member;
   logic              do_add;
   logic              do_del;
   logic              do_swap;

   logic              a_we, s_we;
   logic [SLOT_W-1:0] a_waddr, a_wdata, s_waddr, s_wdata;

   assign req_stall = ex_valid_ff | clr_busy_ff;
   assign accept    = req_valid & ~req_stall;
   assign advance   = ex_valid_ff & (~rsp_valid_ff | ~rsp_stall);

   // range check and read addresses at accept
   always_comb begin
      limit = (32'(universe_ff) < 32'(UNIVERSE_MAX)) ? 32'(universe_ff) : 32'(UNIVERSE_MAX);
      acc_err  = 32'(req_element) >= limit;
      acc_elem = SLOT_W'(req_element);
      if (req_opcode == OP_DELETE) begin
         acc_pos = SLOT_W'(count_ff - CNT_W'(1));
      end else begin
         acc_pos = SLOT_W'(count_ff);
      end
   end

   // execute: forward the pending second write pair of the previous swap, then decide add, delete and swap
   always_comb begin
      from_slot  = rd_slot_ff;
      other_elem = rd_elem_ff;
      if (ex_overlap_ff && ex_elem_ff == wb2_other_ff) begin
         from_slot = wb2_from_ff;
      end
      if (ex_overlap_ff && ex_pos_ff == wb2_from_ff) begin
         other_elem = wb2_other_ff;
      end
      member  = 32'(from_slot) < 32'(count_ff);
      do_add  = ~ex_err_ff && ex_op_ff == OP_ADD && ~member &&
                count_ff < CNT_W'(UNIVERSE_MAX);
      do_del  = ~ex_err_ff && ex_op_ff == OP_DELETE && member;
      do_swap = (do_add | do_del) && from_slot != ex_pos_ff;
   end

   always_comb begin
      count_in     = count_ff;
      wb2_in       = 1'b0;
      wb2_from_in  = wb2_from_ff;
      wb2_other_in = wb2_other_ff;
      ex_valid_in  = ex_valid_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (advance) begin
         ex_valid_in  = 1'b0;
         rsp_valid_in = 1'b1;
         if (do_add) begin
            count_in = count_ff + CNT_W'(1);
         end else if (do_del) begin
            count_in = count_ff - CNT_W'(1);
         end
         if (do_swap) begin
            wb2_in       = 1'b1;
            wb2_from_in  = from_slot;
            wb2_other_in = other_elem;
         end
      end
      if (accept) begin
         ex_valid_in = 1'b1;
      end
   end

   // clearing pass
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_idx_in  = clr_idx_ff;
      if (clr_busy_ff) begin
         clr_idx_in = clr_idx_ff + SLOT_W'(1);
         if (clr_idx_ff == SLOT_W'(UNIVERSE_MAX - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   // memory write ports
   always_comb begin
      a_we    = 1'b0;
      s_we    = 1'b0;
      a_waddr = ex_pos_ff;
      a_wdata = ex_elem_ff;
      s_waddr = ex_elem_ff;
      s_wdata = ex_pos_ff;
      if (clr_busy_ff) begin
         a_we    = 1'b1;
         s_we    = 1'b1;
         a_waddr = clr_idx_ff;
         a_wdata = clr_idx_ff;
         s_waddr = clr_idx_ff;
         s_wdata = clr_idx_ff;
      end else if (wb2_ff) begin
         a_we    = 1'b1;
         s_we    = 1'b1;
         a_waddr = wb2_from_ff;
         a_wdata = wb2_other_ff;
         s_waddr = wb2_other_ff;
         s_wdata = wb2_from_ff;
      end else if (advance && do_swap) begin
         a_we = 1'b1;
         s_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (a_we) begin
         elem_at_slot_mem[a_waddr] <= a_wdata;
      end
      if (accept) begin
         rd_elem_ff <= elem_at_slot_mem[acc_pos];
      end
   end

   always_ff @(posedge clock) begin
      if (s_we) begin
         slot_of_elem_mem[s_waddr] <= s_wdata;
      end
      if (accept) begin
         rd_slot_ff <= slot_of_elem_mem[acc_elem];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         universe_ff  <= UNIVERSE_RESET;
         count_ff     <= '0;
         clr_busy_ff  <= 1'b1;
         clr_idx_ff   <= '0;
         ex_valid_ff  <= 1'b0;
         wb2_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            universe_ff <= csr_wr_data;
         end
         count_ff     <= count_in;
         clr_busy_ff  <= clr_busy_in;
         clr_idx_ff   <= clr_idx_in;
         ex_valid_ff  <= ex_valid_in;
         wb2_ff       <= wb2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wb2_from_ff  <= wb2_from_in;
      wb2_other_ff <= wb2_other_in;
      if (accept) begin
         ex_op_ff      <= req_opcode;
         ex_elem_ff    <= acc_elem;
         ex_pos_ff     <= acc_pos;
         ex_err_ff     <= acc_err;
         ex_overlap_ff <= wb2_ff;
      end
      if (advance) begin
         rsp_member_ff <= member & ~ex_err_ff;
         rsp_count_ff  <= COUNT_W'(32'(count_in));
         rsp_err_ff    <= ex_err_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_was_member   = rsp_member_ff;
   assign rsp_member_count = rsp_count_ff;
   assign rsp_range_error  = rsp_err_ff;

endmodule

// File: sim/sparse_set_membership_core_test.sv
// self-checking testbench for sparse_set_membership_core: queued add, delete, query and spare-opcode
// transactions, a transaction-level model of the set, random request gaps and random receiver stalls
// depends on ssm_pkg and the sparse_set_membership_core rtl

module sparse_set_membership_core_test
   import ssm_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int UNIVERSE_MAX   = 1024;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 300;

   // opcode with no operation of its own, handled as a query
   localparam opcode_type OP_SPARE = 2'd3;

   typedef struct {
      opcode_type  opcode;
      element_type element;
   } set_request_type;

   typedef struct {
      logic      was_member;
      count_type member_count;
      logic      range_error;
   } set_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   opcode_type  req_opcode = OP_ADD;
   element_type req_element = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_was_member;
   count_type   rsp_member_count;
   logic        rsp_range_error;
   logic        csr_wr_en = 1'b0;
   univ_type    csr_wr_data = '0;

   set_request_type pending_requests[$];
   set_result_type  expected_results[$];

   // model of the set
   element_type element_at_slot[UNIVERSE_MAX];
   element_type slot_of_element[UNIVERSE_MAX];
   int          members_held;
   univ_type    universe_held;

   int   issued = 0;
   int   accepted = 0;
   int   checked = 0;
   int   errors = 0;
   int   range_errors = 0;
   int   peak_members = 0;
   int   settings_used = 0;
   int   idle_cycles = 0;
   int   hold_left = 0;
   bit   hold_done = 0;
   bit   req_taken = 0;
   logic calm;

   assign calm = (accepted >= 400) && (accepted < 700);

   sparse_set_membership_core #(
      .UNIVERSE_MAX(UNIVERSE_MAX)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_element(req_element),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_was_member(rsp_was_member),
      .rsp_member_count(rsp_member_count),
      .rsp_range_error(rsp_range_error),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void move_to_slot(int slot, element_type el);
      int          from;
      element_type other;
      from = slot_of_element[el];
      if (from != slot) begin
         other = element_at_slot[slot];
         element_at_slot[slot] = el;
         element_at_slot[from] = other;
         slot_of_element[el] = element_type'(slot);
         slot_of_element[other] = element_type'(from);
      end
   endfunction

   function automatic set_result_type apply_set_op(opcode_type op, element_type el);
      set_result_type r;
      int             limit;
      logic           member;
      limit = (int'(universe_held) > UNIVERSE_MAX) ? UNIVERSE_MAX : int'(universe_held);
      r.was_member = 1'b0;
      r.range_error = 1'b0;
      if (int'(el) >= limit) begin
         r.range_error = 1'b1;
         r.member_count = count_type'(members_held);
         return r;
      end
      member = int'(slot_of_element[el]) < members_held;
      if (op == OP_ADD) begin
         if (!member && members_held < UNIVERSE_MAX) begin
            move_to_slot(members_held, el);
            members_held++;
         end
      end else if (op == OP_DELETE) begin
         if (member && members_held > 0) begin
            move_to_slot(members_held - 1, el);
            members_held--;
         end
      end
      r.was_member = member;
      r.member_count = count_type'(members_held);
      return r;
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_requests.size() > 0 && (calm || $urandom_range(99) >= 27)) begin
            req_valid <= 1'b1;
            req_opcode <= pending_requests[0].opcode;
            req_element <= pending_requests[0].element;
            void'(pending_requests.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall, with one long hold-off while requests keep coming
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!hold_done && accepted >= 900) begin
         hold_done = 1;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 27);
      end
   end

   // monitor, model update and watchdog
   always @(posedge clock) begin
      set_result_type exp_r;
      bit             fired;
      fired = 0;
      req_taken = 0;
      if (reset) begin
         for (int i = 0; i < UNIVERSE_MAX; i++) begin
            element_at_slot[i] = element_type'(i);
            slot_of_element[i] = element_type'(i);
         end
         members_held = 0;
         universe_held = UNIVERSE_RESET;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            fired = 1;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result was_member %0b count %0d range_error %0b",
                        $time, rsp_was_member, rsp_member_count, rsp_range_error);
               errors++;
            end else begin
               exp_r = expected_results.pop_front();
               checked++;
               if (rsp_was_member !== exp_r.was_member) begin
                  $display("%0t: was_member expected %0b actual %0b",
                           $time, exp_r.was_member, rsp_was_member);
                  errors++;
               end
               if (rsp_member_count !== exp_r.member_count) begin
                  $display("%0t: member_count expected %0d actual %0d",
                           $time, exp_r.member_count, rsp_member_count);
                  errors++;
               end
               if (rsp_range_error !== exp_r.range_error) begin
                  $display("%0t: range_error expected %0b actual %0b",
                           $time, exp_r.range_error, rsp_range_error);
                  errors++;
               end
            end
         end
         if (csr_wr_en) begin
            universe_held = csr_wr_data;
         end
         if (req_valid && !req_stall) begin
            fired = 1;
            req_taken = 1;
            exp_r = apply_set_op(req_opcode, req_element);
            if (exp_r.range_error) begin
               range_errors++;
            end
            if (members_held > peak_members) begin
               peak_members = members_held;
            end
            expected_results.push_back(exp_r);
            accepted++;
         end
         if (fired || (issued == accepted && checked == accepted)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("FAIL sparse_set_membership_core");
            $finish;
         end
      end
   end

   task automatic issue(opcode_type op, int el);
      set_request_type req;
      req.opcode = op;
      req.element = element_type'(el);
      pending_requests.push_back(req);
      issued++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (accepted != issued || checked != accepted) begin
         @(negedge clock);
      end
   endtask

   task automatic set_universe(int value);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= univ_type'(value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   function automatic int pick_element(int limit);
      if (limit == 0 || $urandom_range(99) < 12) begin
         return $urandom_range(1023);
      end
      return $urandom_range(limit - 1);
   endfunction

   task automatic issue_random(int n, int limit);
      for (int i = 0; i < n; i++) begin
         issue(opcode_type'($urandom_range(3)), pick_element(limit));
      end
   endtask

   // every element added once in shuffled order, plus stray queries, adds and spare ops, with no deletes mixed in
   task automatic issue_fill();
      int order[UNIVERSE_MAX];
      int j;
      int tmp;
      for (int i = 0; i < UNIVERSE_MAX; i++) begin
         order[i] = i;
      end
      for (int i = UNIVERSE_MAX - 1; i > 0; i--) begin
         j = $urandom_range(i);
         tmp = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      for (int i = 0; i < UNIVERSE_MAX; i++) begin
         issue(OP_ADD, order[i]);
         if ($urandom_range(99) < 12) begin
            case ($urandom_range(2))
               0: begin
                  issue(OP_QUERY, $urandom_range(1023));
               end
               1: begin
                  issue(OP_ADD, $urandom_range(1023));
               end
               default: begin
                  issue(OP_SPARE, $urandom_range(1023));
               end
            endcase
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed
      issue(OP_ADD, 0);
      issue(OP_ADD, 1023);
      issue(OP_QUERY, 0);
      issue(OP_QUERY, 1023);
      issue(OP_ADD, 0);
      issue(OP_DELETE, 5);
      issue(OP_SPARE, 1023);
      issue(OP_ADD, 512);
      issue(OP_DELETE, 0);
      issue(OP_DELETE, 512);
      issue(OP_ADD, 1000);
      issue(OP_QUERY, 1);
      set_universe(0);
      issue(OP_ADD, 0);
      issue(OP_QUERY, 1023);
      set_universe(1);
      issue(OP_ADD, 0);
      issue(OP_ADD, 1);
      issue(OP_DELETE, 0);
      set_universe(600);
      issue(OP_QUERY, 1000);
      issue(OP_DELETE, 1023);
      issue(OP_ADD, 599);
      issue(OP_ADD, 600);
      set_universe(2047);
      issue(OP_QUERY, 1000);
      issue(OP_DELETE, 1000);
      issue(OP_ADD, 1023);

      // random
      set_universe(16);
      issue_random(150, 16);
      set_universe(300);
      issue_random(100, 300);
      set_universe(2047);
      issue_fill();
      issue_random(8, 1024);
      set_universe(0);
      issue_random(10, 0);
      set_universe(1);
      issue_random(10, 1);
      set_universe(1024);
      issue_random(60, 1024);

      wait_idle();
      repeat (20) @(negedge clock);
      $display("covered %0d transactions over %0d universe settings", accepted, settings_used);
      $display("%0d range errors, peak of %0d members", range_errors, peak_members);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("PASS sparse_set_membership_core");
      end else begin
         $display("FAIL sparse_set_membership_core");
      end
      $finish;
   end

endmodule

// File: sim.f
design/ssm_pkg.sv
design/sparse_set_membership_core.sv
sim/sparse_set_membership_core_test.sv
